// ===== sv/fixed_step_frame_pacer_assert.svh =====
// Assertion macros for the frame pacer.
// Included by the top level; needs nothing else.
`ifndef FIXED_STEP_FRAME_PACER_ASSERT_SVH
`define FIXED_STEP_FRAME_PACER_ASSERT_SVH

// Same-cycle implication under reset.
`define FSFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define FSFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fsfp_pkg.sv =====
// Package for the frame pacer: widths, constants, register codes and state type.
// No dependencies.
package fsfp_pkg;

    localparam int SAMPLES    = 16;
    localparam int SKIP_BOUND = 64;

    localparam int PERIOD_W = 30;
    localparam int SKIP_W   = 7;
    localparam int DELAY_W  = 30;
    localparam int RATE_W   = 24;
    localparam int ACC_W    = 31;
    localparam int STAMP_W  = 64;
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLES);
    localparam int SUB_W    = SUM_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int WIN_IDX_W  = $clog2(SAMPLES);

    localparam logic [STAMP_W-1:0]  CLAMP_NS     = 64'd100_000_000;
    localparam logic [DELAY_W-1:0]  MIN_DELAY_NS = 30'd500_000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd16_666_666;
    localparam logic [SKIP_W-1:0]   SKIP_RESET   = 7'd5;
    localparam logic [SKIP_W-1:0]   SKIP_LIMIT   = SKIP_W'(SKIP_BOUND);
    localparam logic [RATE_W-1:0]   RATE_RESET   = 24'd15360;
    localparam logic [RATE_W-1:0]   RATE_MAX     = {RATE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = {SAMPLE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = SAMPLE_W'(PERIOD_RESET);
    localparam logic [63:0]         SUM_RESET64  = 64'(SAMPLES) * 64'd16_666_666;
    localparam logic [SUM_W-1:0]    SUM_RESET    = SUM_RESET64[SUM_W-1:0];

    // 1e9 * SAMPLES * 256: dividend of the rate division
    localparam logic [63:0] RATE_NUM   = 64'd1_000_000_000 * 64'(SAMPLES) * 64'd256;
    localparam int          NUM_W      = $clog2(RATE_NUM + 64'd1);
    localparam int          DIV_CNT_W  = $clog2(NUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DLY,
        ST_DIV,
        ST_RATE,
        ST_DONE
    } fsfp_state_t;

endpackage

// ===== sv/fsfp_if.sv =====
// Handshake channels of the frame pacer: input word and result word.
// Depends on fsfp_pkg for field widths.
interface fsfp_item_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [fsfp_pkg::STAMP_W-1:0]  now_ns;

    modport source (output valid, op, now_ns, input ready);
    modport sink   (input valid, op, now_ns, output ready);
endinterface

interface fsfp_result_if;
    logic                          valid;
    logic                          ready;
    logic [fsfp_pkg::SKIP_W-1:0]   updates;
    logic                          skip_limit_hit;
    logic [fsfp_pkg::DELAY_W-1:0]  delay_ns;
    logic [fsfp_pkg::RATE_W-1:0]   rate_q8;
    logic [fsfp_pkg::ACC_W-1:0]    accumulated_ns;

    modport source (output valid, updates, skip_limit_hit, delay_ns, rate_q8,
                    accumulated_ns, input ready);
    modport sink   (input valid, updates, skip_limit_hit, delay_ns, rate_q8,
                    accumulated_ns, output ready);
endinterface

// ===== sv/fixed_step_frame_pacer.sv =====
// Fixed-step frame pacer with a moving-average frame rate, top level.
// Depends on fsfp_pkg, fsfp_if.sv and fixed_step_frame_pacer_assert.svh.
//
// Takes one word at a time; ready is high only while the sequencer is idle.
// A begin-frame word is accepted, then runs one step per granted update plus
// a final check on the shared subtractor (updates capped by the skip register,
// clamped to SKIP_LIMIT), then the delay compare and the result hand-over.
// An end-frame word runs the 42-step restoring division of the rate on the
// same subtractor. The result sits in an output register, so the next word
// is taken while it waits. Configuration writes land at once; the period is
// read at every update step, the skip limit when a word is taken.
`include "fixed_step_frame_pacer_assert.svh"

module fixed_step_frame_pacer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsfp_pkg::PERIOD_W-1:0]   cfg_data,
    fsfp_item_if.sink                       item,
    fsfp_result_if.source                   result
);
    import fsfp_pkg::*;

    fsfp_state_t            state_reg, state_next;
    logic [PERIOD_W-1:0]    period_reg;
    logic [SKIP_W-1:0]      skip_reg;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [SAMPLE_W-1:0]    win_reg [SAMPLES];
    logic                   win_shift;
    logic [SAMPLE_W-1:0]    sample;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [SUB_W-1:0]       work_reg, work_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [SKIP_W-1:0]      cnt_reg, cnt_next;
    logic [SKIP_W-1:0]      limit_reg, limit_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   hit_reg, hit_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SKIP_W-1:0]      out_updates_reg, out_updates_next;
    logic                   out_hit_reg, out_hit_next;
    logic [DELAY_W-1:0]     out_delay_reg, out_delay_next;
    logic [RATE_W-1:0]      out_rate_reg, out_rate_next;
    logic [ACC_W-1:0]       out_acc_reg, out_acc_next;

    logic [STAMP_W-1:0]     elapsed;
    logic [ACC_W-1:0]       clamped;
    logic [SUB_W-1:0]       sub_a, sub_b;
    logic [SUB_W:0]         diff;
    logic                   borrow;

    assign item.ready            = (state_reg == ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.updates        = out_updates_reg;
    assign result.skip_limit_hit = out_hit_reg;
    assign result.delay_ns       = out_delay_reg;
    assign result.rate_q8        = out_rate_reg;
    assign result.accumulated_ns = out_acc_reg;

    assign elapsed = item.now_ns - stamp_reg;
    assign clamped = (elapsed > CLAMP_NS) ? CLAMP_NS[ACC_W-1:0] : elapsed[ACC_W-1:0];
    assign sample  = (|elapsed[STAMP_W-1:SAMPLE_W]) ? SAMPLE_MAX : elapsed[SAMPLE_W-1:0];

    // shared subtractor
    always_comb
    begin
        case (state_reg)
            ST_STEP:
            begin
                sub_a = work_reg;
                sub_b = SUB_W'(period_reg);
            end
            ST_DLY:
            begin
                sub_a = SUB_W'(period_reg);
                sub_b = work_reg;
            end
            ST_DIV:
            begin
                sub_a = {work_reg[SUB_W-2:0], quo_reg[NUM_W-1]};
                sub_b = SUB_W'(sum_reg);
            end
            default:
            begin
                sub_a = work_reg;
                sub_b = '0;
            end
        endcase
    end

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[SUB_W];

    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        stamp_next       = stamp_reg;
        sum_next         = sum_reg;
        rate_next        = rate_reg;
        work_next        = work_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        limit_next       = limit_reg;
        div_cnt_next     = div_cnt_reg;
        hit_next         = hit_reg;
        delay_next       = delay_reg;
        win_shift        = 1'b0;
        out_valid_next   = out_valid_reg & ~result.ready;
        out_updates_next = out_updates_reg;
        out_hit_next     = out_hit_reg;
        out_delay_next   = out_delay_reg;
        out_rate_next    = out_rate_reg;
        out_acc_next     = out_acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    delay_next = '0;
                    if (!item.op)
                    begin
                        work_next  = SUB_W'(acc_reg) + SUB_W'(clamped);
                        stamp_next = item.now_ns;
                        limit_next = (skip_reg > SKIP_LIMIT) ? SKIP_LIMIT : skip_reg;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        win_shift    = 1'b1;
                        sum_next     = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(sample);
                        work_next    = '0;
                        quo_next     = RATE_NUM[NUM_W-1:0];
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_STEP:
            begin
                if (cnt_reg < limit_reg && !borrow)
                begin
                    work_next = diff[SUB_W-1:0];
                    cnt_next  = cnt_reg + SKIP_W'(1);
                end
                else
                begin
                    // limit reached: drop the remainder
                    if (cnt_reg >= limit_reg)
                    begin
                        hit_next  = 1'b1;
                        work_next = '0;
                    end
                    else
                    begin
                        work_next = SUB_W'(work_reg[ACC_W-1:0]);
                    end
                    state_next = ST_DLY;
                end
            end
            ST_DLY:
            begin
                if (!borrow && diff[SUB_W-1:0] != '0 && diff[DELAY_W-1:0] > MIN_DELAY_NS)
                begin
                    delay_next = diff[DELAY_W-1:0];
                end
                acc_next   = work_reg[ACC_W-1:0];
                state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (!borrow)
                begin
                    work_next = diff[SUB_W-1:0];
                end
                else
                begin
                    work_next = sub_a;
                end
                quo_next     = {quo_reg[NUM_W-2:0], ~borrow};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (sum_reg == '0 || |quo_reg[NUM_W-1:RATE_W])
                begin
                    rate_next = RATE_MAX;
                end
                else
                begin
                    rate_next = quo_reg[RATE_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_updates_next = cnt_reg;
                    out_hit_next     = hit_reg;
                    out_delay_next   = delay_reg;
                    out_rate_next    = rate_reg;
                    out_acc_next     = acc_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            skip_reg      <= SKIP_RESET;
            acc_reg       <= '0;
            stamp_reg     <= '0;
            sum_reg       <= SUM_RESET;
            rate_reg      <= RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_PERIOD)
            begin
                period_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SKIP)
            begin
                skip_reg <= cfg_data[SKIP_W-1:0];
            end
            acc_reg       <= acc_next;
            stamp_reg     <= stamp_next;
            sum_reg       <= sum_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLES; i++)
            begin
                win_reg[i] <= SAMPLE_RESET;
            end
        end
        else if (win_shift)
        begin
            for (int i = 0; i < SAMPLES - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[SAMPLES - 1] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        limit_reg       <= limit_next;
        div_cnt_reg     <= div_cnt_next;
        hit_reg         <= hit_next;
        delay_reg       <= delay_next;
        out_updates_reg <= out_updates_next;
        out_hit_reg     <= out_hit_next;
        out_delay_reg   <= out_delay_next;
        out_rate_reg    <= out_rate_next;
        out_acc_reg     <= out_acc_next;
    end

    `FSFP_ASSERT_NXT(a_div_done, clk, rst_n, state_reg == ST_DIV && div_cnt_reg == DIV_LAST, state_reg == ST_RATE, "divider did not finish on its last step")
    `FSFP_ASSERT_IMP(a_step_bound, clk, rst_n, state_reg == ST_STEP, cnt_reg <= limit_reg && limit_reg <= SKIP_LIMIT, "step count past its limit")
    `FSFP_ASSERT_IMP(a_hit_clears, clk, rst_n, result.valid && result.skip_limit_hit, result.accumulated_ns == '0, "limit hit without clearing the accumulator")
    `FSFP_ASSERT_IMP(a_delay_floor, clk, rst_n, result.valid && result.delay_ns != '0, result.delay_ns > MIN_DELAY_NS, "delay below floor")

endmodule
